### src/chained_hash_set_macros.svh
// assertion macros shared by the hash set rtl
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CHS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chained_hash_set check failed");
// next-cycle implication, checked out of reset
`define CHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chained_hash_set check failed");
`else
`define CHS_ASSERT_IMPL(label, ante, cons)
`define CHS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/chs_pkg.sv
// types and constants of the chained hash set
package chs_pkg;

  localparam int BUCKETS  = 1024;
  localparam int NODES    = 1024;
  localparam int KEY_BITS = 31;

  // fixed field widths
  localparam int IN_KEY_W = 31;
  localparam int CFG_W    = 11;
  localparam int VAL_W    = 32;

  localparam int KEY_W  = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int NODE_W = $clog2(NODES);
  localparam int PTR_W  = $clog2(NODES + 1);
  localparam int MOD_W  = $clog2(BUCKETS + 1);
  localparam int STEP_W = $clog2(KEY_W);

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(1021);
  localparam logic [VAL_W-1:0] NO_VALUE         = '1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_NODE_RD,
    ST_NODE_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [MOD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } mod_rsp_t;

endpackage

### src/chs_in_if.sv
// request channel: command and key
interface chs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [chs_pkg::IN_KEY_W-1:0]  key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

### src/chs_out_if.sv
// result channel: found flag, value and status
interface chs_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [chs_pkg::VAL_W-1:0]  lookup_value;
  logic                              status;

  modport source (output valid, output found, output lookup_value, output status,
                  input ready);
  modport sink   (input valid, input found, input lookup_value, input status,
                  output ready);
endinterface

### src/chs_mod.sv
// bit-serial remainder unit: key modulo bucket count, one key bit a cycle
`include "chained_hash_set_macros.svh"

module chs_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  chs_pkg::mod_req_t req,
  output chs_pkg::mod_rsp_t rsp
);

  localparam logic [chs_pkg::STEP_W-1:0] STEP_ONE = chs_pkg::STEP_W'(1);

  logic                         busy_r;
  logic                         done_r;
  logic [chs_pkg::STEP_W-1:0]   cnt_r;
  logic [chs_pkg::MOD_W-1:0]    rem_r;
  logic [chs_pkg::KEY_W-1:0]    dvd_r;
  logic [chs_pkg::MOD_W-1:0]    div_r;

  logic [chs_pkg::MOD_W:0]      trial;
  logic [chs_pkg::MOD_W:0]      rem_step;
  logic [chs_pkg::MOD_W-1:0]    rem_nxt;

  // restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[chs_pkg::KEY_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_step = trial - {1'b0, div_r};
    end else begin
      rem_step = trial;
    end
    rem_nxt = rem_step[chs_pkg::MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_ONE;
        if (cnt_r == chs_pkg::STEP_W'(chs_pkg::KEY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[chs_pkg::KEY_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  `CHS_ASSERT_IMPL(a_mod_no_restart, req.start, !busy_r)
  `CHS_ASSERT_NEXT(a_mod_done_pulse, done_r, !done_r && !busy_r)
  `CHS_ASSERT_IMPL(a_mod_rem_bound, busy_r, rem_r < div_r)

endmodule

### src/chained_hash_set.sv
// top level of the chained hash set: sequencer, bucket and node memories
// After reset the block sweeps the 1024-entry bucket head memory to empty with
// ready low; configuration writes are taken meanwhile. Each command then goes
// through these steps in order: acceptance, the bit-serial remainder unit that
// computes key modulo bucket count, a read of the bucket head, one read from the
// registered-read node memories per chain node visited (the whole chain for an
// insert, up to the first match for a lookup) and the hand-over of the result.
// An insert into a full pool skips the memories and answers status 1. The next
// command is accepted once the result sits in the output register, even if the
// sink has not yet taken it.
`include "chained_hash_set_macros.svh"

module chained_hash_set (
  input  logic                      clk,
  input  logic                      rst_n,
  chs_in_if.sink                    in_ch,
  chs_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [chs_pkg::CFG_W-1:0] cfg_wr_data
);

  chs_pkg::state_t state_r, state_nxt;

  logic [chs_pkg::CFG_W-1:0]  bucket_count_r;
  logic                       cmd_r, cmd_nxt;
  logic [chs_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [chs_pkg::BKT_W-1:0]  bucket_r, bucket_nxt;
  logic [chs_pkg::PTR_W-1:0]  cur_r, cur_nxt;
  logic                       found_r, found_nxt;
  logic                       drop_r, drop_nxt;
  logic [chs_pkg::PTR_W-1:0]  nodes_used_r, nodes_used_nxt;
  logic [chs_pkg::BKT_W-1:0]  clr_idx_r, clr_idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r;
  logic [chs_pkg::VAL_W-1:0]  out_value_r;
  logic                       out_status_r;
  logic                       out_load;

  chs_pkg::mod_req_t          mod_req;
  chs_pkg::mod_rsp_t          mod_rsp;
  logic [chs_pkg::MOD_W-1:0]  modulus;

  // memories
  logic [chs_pkg::PTR_W-1:0]  head_mem [chs_pkg::BUCKETS];
  logic [chs_pkg::KEY_W-1:0]  key_mem  [chs_pkg::NODES];
  logic [chs_pkg::PTR_W-1:0]  link_mem [chs_pkg::NODES];

  logic                       head_we;
  logic [chs_pkg::BKT_W-1:0]  head_waddr;
  logic [chs_pkg::PTR_W-1:0]  head_wdata;
  logic [chs_pkg::PTR_W-1:0]  head_q;
  logic                       key_we;
  logic                       link_we;
  logic [chs_pkg::NODE_W-1:0] link_waddr;
  logic [chs_pkg::PTR_W-1:0]  link_wdata;
  logic [chs_pkg::NODE_W-1:0] fresh_idx;
  logic [chs_pkg::PTR_W-1:0]  cur_minus;
  logic [chs_pkg::NODE_W-1:0] node_raddr;
  logic [chs_pkg::KEY_W-1:0]  key_q;
  logic [chs_pkg::PTR_W-1:0]  link_q;

  logic                       in_ready;
  logic                       in_fire;
  logic                       pool_full;

  localparam logic [chs_pkg::PTR_W-1:0] PTR_ONE = chs_pkg::PTR_W'(1);
  localparam logic [chs_pkg::BKT_W-1:0] BKT_ONE = chs_pkg::BKT_W'(1);

  assign in_fire    = in_ch.valid && in_ready;
  assign pool_full  = (nodes_used_r == chs_pkg::PTR_W'(chs_pkg::NODES));
  assign fresh_idx  = nodes_used_r[chs_pkg::NODE_W-1:0];
  assign cur_minus  = cur_r - PTR_ONE;
  assign node_raddr = cur_minus[chs_pkg::NODE_W-1:0];

  // zero counts as one, values above the table size saturate
  always_comb begin
    if (bucket_count_r == '0) begin
      modulus = chs_pkg::MOD_W'(1);
    end else if (32'(bucket_count_r) > 32'(chs_pkg::BUCKETS)) begin
      modulus = chs_pkg::MOD_W'(chs_pkg::BUCKETS);
    end else begin
      modulus = chs_pkg::MOD_W'(bucket_count_r);
    end
  end

  chs_mod u_mod (
    .clk (clk),
    .rst_n (rst_n),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chs_pkg::ST_CLEAR: begin
        if (clr_idx_r == chs_pkg::BKT_W'(chs_pkg::BUCKETS - 1)) begin
          state_nxt = chs_pkg::ST_IDLE;
        end
      end
      chs_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = chs_pkg::ST_HASH;
        end
      end
      chs_pkg::ST_HASH: begin
        if (mod_rsp.done) begin
          if (cmd_r == chs_pkg::CMD_INSERT && pool_full) begin
            state_nxt = chs_pkg::ST_DONE;
          end else begin
            state_nxt = chs_pkg::ST_HEAD_RD;
          end
        end
      end
      chs_pkg::ST_HEAD_RD: state_nxt = chs_pkg::ST_HEAD_CHK;
      chs_pkg::ST_HEAD_CHK: begin
        if (head_q == '0) begin
          state_nxt = chs_pkg::ST_DONE;
        end else begin
          state_nxt = chs_pkg::ST_NODE_RD;
        end
      end
      chs_pkg::ST_NODE_RD: state_nxt = chs_pkg::ST_NODE_CHK;
      chs_pkg::ST_NODE_CHK: begin
        if (link_q == '0 || (cmd_r == chs_pkg::CMD_LOOKUP && key_q == key_r)) begin
          state_nxt = chs_pkg::ST_DONE;
        end else begin
          state_nxt = chs_pkg::ST_NODE_RD;
        end
      end
      chs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = chs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chs_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready         = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = key_r;
    mod_req.divisor  = modulus;
    head_we          = 1'b0;
    head_waddr       = bucket_r;
    head_wdata       = '0;
    key_we           = 1'b0;
    link_we          = 1'b0;
    link_waddr       = fresh_idx;
    link_wdata       = '0;
    out_load         = 1'b0;
    cmd_nxt          = cmd_r;
    key_nxt          = key_r;
    bucket_nxt       = bucket_r;
    cur_nxt          = cur_r;
    found_nxt        = found_r;
    drop_nxt         = drop_r;
    nodes_used_nxt   = nodes_used_r;
    clr_idx_nxt      = clr_idx_r;
    case (state_r)
      chs_pkg::ST_CLEAR: begin
        head_we     = 1'b1;
        head_waddr  = clr_idx_r;
        clr_idx_nxt = clr_idx_r + BKT_ONE;
      end
      chs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt          = in_ch.command;
          key_nxt          = in_ch.key[chs_pkg::KEY_W-1:0];
          found_nxt        = 1'b0;
          drop_nxt         = 1'b0;
          mod_req.start    = 1'b1;
          mod_req.dividend = in_ch.key[chs_pkg::KEY_W-1:0];
        end
      end
      chs_pkg::ST_HASH: begin
        if (mod_rsp.done) begin
          bucket_nxt = mod_rsp.rem[chs_pkg::BKT_W-1:0];
          drop_nxt   = (cmd_r == chs_pkg::CMD_INSERT) && pool_full;
        end
      end
      chs_pkg::ST_HEAD_CHK: begin
        cur_nxt = head_q;
        if (cmd_r == chs_pkg::CMD_INSERT) begin
          // new node gets key and an end link no later than the first pointer to it is written
          key_we         = 1'b1;
          link_we        = 1'b1;
          nodes_used_nxt = nodes_used_r + PTR_ONE;
          if (head_q == '0) begin
            head_we    = 1'b1;
            head_wdata = nodes_used_r + PTR_ONE;
          end
        end
      end
      chs_pkg::ST_NODE_CHK: begin
        cur_nxt = link_q;
        if (cmd_r == chs_pkg::CMD_LOOKUP) begin
          if (key_q == key_r) begin
            found_nxt = 1'b1;
          end
        end else if (link_q == '0) begin
          // count was bumped already, so it now equals fresh node plus one
          link_we    = 1'b1;
          link_waddr = node_raddr;
          link_wdata = nodes_used_r;
        end
      end
      chs_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= chs_pkg::ST_CLEAR;
      bucket_count_r <= chs_pkg::BUCKET_COUNT_RST;
      nodes_used_r   <= '0;
      clr_idx_r      <= '0;
      out_valid_r    <= 1'b0;
      found_r        <= 1'b0;
      drop_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      clr_idx_r    <= clr_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      found_r      <= found_nxt;
      drop_r       <= drop_nxt;
      if (cfg_wr_en) begin
        bucket_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    bucket_r <= bucket_nxt;
    cur_r    <= cur_nxt;
    if (out_load) begin
      out_found_r  <= found_r;
      out_status_r <= drop_r;
      out_value_r  <= found_r ? chs_pkg::VAL_W'(key_r) : chs_pkg::NO_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[fresh_idx] <= key_r;
    end
    key_q <= key_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[node_raddr];
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.lookup_value = out_value_r;
  assign out_ch.status       = out_status_r;

  `CHS_ASSERT_IMPL(a_pool_bound, 1'b1, nodes_used_r <= chs_pkg::PTR_W'(chs_pkg::NODES))
  `CHS_ASSERT_NEXT(a_accept_hash, in_fire, state_r == chs_pkg::ST_HASH)
  `CHS_ASSERT_IMPL(a_done_in_hash, mod_rsp.done, state_r == chs_pkg::ST_HASH)
  `CHS_ASSERT_IMPL(a_drop_no_hit, out_valid_r && out_status_r, !out_found_r)

endmodule

### tb/chained_hash_set_tb.sv
`timescale 1ns / 100ps
// testbench of the chained hash set: directed and random commands checked against a mirror
module chained_hash_set_tb;

  typedef logic [chs_pkg::IN_KEY_W-1:0] key_t;

  typedef struct {
    logic                             found;
    logic signed [chs_pkg::VAL_W-1:0] lookup_value;
    logic                             status;
  } answer_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [chs_pkg::CFG_W-1:0] cfg_wr_data;

  chs_in_if  in_ch ();
  chs_out_if out_ch ();

  chained_hash_set dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // mirror of the set: heads and links hold node index plus one, zero is empty
  logic [chs_pkg::CFG_W-1:0] bucket_count_mirror;
  int unsigned               head_mirror [chs_pkg::BUCKETS];
  key_t                      node_key_mirror [chs_pkg::NODES];
  int unsigned               node_link_mirror [chs_pkg::NODES];
  int unsigned               nodes_used_mirror;

  answer_t pending_answers [$];
  key_t    stored_keys [$];
  answer_t due;
  int      mismatches = 0;
  bit      no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #120_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // works out the answer to one command and updates the mirror
  function automatic answer_t hash_set_answer(logic cmd, key_t key);
    answer_t     a;
    int unsigned modv;
    int unsigned bkt;
    int unsigned cur;
    a.found        = 1'b0;
    a.lookup_value = chs_pkg::NO_VALUE;
    a.status       = 1'b0;
    if (bucket_count_mirror == 0) modv = 1;
    else if (bucket_count_mirror > chs_pkg::BUCKETS) modv = chs_pkg::BUCKETS;
    else modv = bucket_count_mirror;
    bkt = key % modv;
    cur = head_mirror[bkt];
    if (cmd == chs_pkg::CMD_INSERT) begin
      if (nodes_used_mirror >= chs_pkg::NODES) begin
        a.status = 1'b1;
        return a;
      end
      node_key_mirror[nodes_used_mirror]  = key;
      node_link_mirror[nodes_used_mirror] = 0;
      nodes_used_mirror++;
      if (cur == 0) begin
        head_mirror[bkt] = nodes_used_mirror;
      end else begin
        while (node_link_mirror[cur-1] != 0) cur = node_link_mirror[cur-1];
        node_link_mirror[cur-1] = nodes_used_mirror;
      end
      stored_keys.push_back(key);
    end else begin
      while (cur != 0 && !a.found) begin
        if (node_key_mirror[cur-1] == key) begin
          a.found        = 1'b1;
          a.lookup_value = {1'b0, key};
        end else begin
          cur = node_link_mirror[cur-1];
        end
      end
    end
    return a;
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic push_word(logic cmd, key_t key);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 33) gap = $urandom_range(1, 40);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= key;
    do @(posedge clk); while (!in_ch.ready);
    pending_answers.push_back(hash_set_answer(cmd, key));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [chs_pkg::CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bucket_count_mirror = value;
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? key_t'('1) : key_t'('0);
      1, 2:    return key_t'($urandom_range(0, 4095));
      default: return key_t'($urandom);
    endcase
  endfunction

  // mostly inserts and lookups of stored keys, some near misses and noise
  task automatic run_mix(int items, int insert_pct);
    logic        cmd;
    key_t        k;
    int unsigned r;
    for (int i = 0; i < items; i++) begin
      cmd = ($urandom_range(99) < insert_pct) ? chs_pkg::CMD_INSERT : chs_pkg::CMD_LOOKUP;
      k   = pick_key();
      if (stored_keys.size() != 0) begin
        r = $urandom_range(9);
        if (cmd == chs_pkg::CMD_LOOKUP && r < 6) begin
          k = stored_keys[$urandom_range(stored_keys.size() - 1)];
        end else if (cmd == chs_pkg::CMD_LOOKUP && r < 8) begin
          // same bucket unless the modulus saturates or the sum wraps, different key: walks the whole chain
          k = stored_keys[$urandom_range(stored_keys.size() - 1)] + key_t'(bucket_count_mirror);
        end else if (cmd == chs_pkg::CMD_INSERT && r == 0) begin
          k = stored_keys[$urandom_range(stored_keys.size() - 1)];
        end
      end
      push_word(cmd, k);
    end
  endtask

  task automatic test_chains_and_misses();
    push_word(chs_pkg::CMD_LOOKUP, key_t'(0));
    push_word(chs_pkg::CMD_INSERT, key_t'(0));
    push_word(chs_pkg::CMD_INSERT, '1);
    push_word(chs_pkg::CMD_INSERT, key_t'(1021));
    push_word(chs_pkg::CMD_INSERT, key_t'(2042));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(2042));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(0));
    push_word(chs_pkg::CMD_LOOKUP, '1);
    push_word(chs_pkg::CMD_LOOKUP, key_t'(3063));
    push_word(chs_pkg::CMD_INSERT, key_t'(0));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(1));
  endtask

  task automatic test_modulus_extremes();
    // zero count hashes everything to one bucket; old chains stay put
    settle();
    write_bucket_count('0);
    push_word(chs_pkg::CMD_INSERT, key_t'(5));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(5));
    push_word(chs_pkg::CMD_LOOKUP, '1);
    push_word(chs_pkg::CMD_LOOKUP, key_t'(2042));
    // above the bucket range the modulus saturates
    settle();
    write_bucket_count('1);
    push_word(chs_pkg::CMD_INSERT, key_t'(1023));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(1023));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(0));
    push_word(chs_pkg::CMD_INSERT, '1);
    push_word(chs_pkg::CMD_LOOKUP, '1);
    settle();
    write_bucket_count(chs_pkg::CFG_W'(1));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(5));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(1023));
    settle();
    write_bucket_count(chs_pkg::CFG_W'(1025));
    push_word(chs_pkg::CMD_LOOKUP, key_t'(1023));
  endtask

  task automatic test_wide_buckets();
    settle();
    write_bucket_count(chs_pkg::CFG_W'(1021));
    run_mix(430, 50);
  endtask

  task automatic test_few_buckets();
    settle();
    write_bucket_count(chs_pkg::CFG_W'(7));
    run_mix(300, 40);
  endtask

  task automatic test_saturated_modulus();
    settle();
    write_bucket_count(chs_pkg::CFG_W'(2047));
    no_idle = 1'b1;
    run_mix(150, 50);
    no_idle = 1'b0;
    run_mix(250, 50);
  endtask

  task automatic test_two_buckets();
    settle();
    write_bucket_count(chs_pkg::CFG_W'(2));
    run_mix(200, 50);
  endtask

  task automatic test_pool_exhaustion();
    settle();
    write_bucket_count(chs_pkg::CFG_W'(1024));
    while (nodes_used_mirror < chs_pkg::NODES) run_mix(1, 85);
    run_mix(80, 50);
  endtask

  // sink side: checks each taken word and stalls at random
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result word with no command waiting", 0, 0);
      end else begin
        due = pending_answers.pop_front();
        if (out_ch.found !== due.found)
          report_mismatch("found", due.found, out_ch.found);
        if (out_ch.lookup_value !== due.lookup_value)
          report_mismatch("lookup_value", due.lookup_value, out_ch.lookup_value);
        if (out_ch.status !== due.status)
          report_mismatch("status", due.status, out_ch.status);
      end
    end
    out_ch.ready <= no_idle || ($urandom_range(99) >= 33);
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= chs_pkg::CMD_INSERT;
    in_ch.key     <= '0;
    no_idle             = 1'b0;
    bucket_count_mirror = chs_pkg::BUCKET_COUNT_RST;
    nodes_used_mirror   = 0;
    foreach (head_mirror[i]) head_mirror[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_chains_and_misses();
    test_modulus_extremes();
    test_wide_buckets();
    test_few_buckets();
    test_saturated_modulus();
    test_two_buckets();
    test_pool_exhaustion();

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
